// File: rtl/sorted_key_table_find_or_insert_defines.svh
// Assertion macros used by the sorted key table engine.
`ifndef SORTED_KEY_TABLE_FIND_OR_INSERT_DEFINES_SVH
`define SORTED_KEY_TABLE_FIND_OR_INSERT_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define SKTFI_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define SKTFI_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/sktfi_pkg.sv
// Shared types and constants of the sorted key table.
package sktfi_pkg;

	localparam int KEY_W  = 31;
	localparam int SLOT_W = 6;
	localparam int USED_W = 7;

	// Request handed from the input queue to the search engine.
	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
	} sktfi_req_t;

endpackage

// File: rtl/sktfi_front.sv
// Input side: accept keys and hold them in a two-entry queue for the engine.
module sktfi_front import sktfi_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [KEY_W-1:0] lookup_key,
	output sktfi_req_t       req,
	input  logic             pop
);

	logic [KEY_W-1:0] entry_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       fill_q;
	logic             push;
	logic             pull;

	assign in_ready  = (fill_q != 2'd2);
	assign push      = in_valid && in_ready;
	assign pull      = pop && (fill_q != 2'd0);
	assign req.valid = (fill_q != 2'd0);
	assign req.key   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= lookup_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pull) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pull) begin
				fill_q <= fill_q + 2'd1;
			end else if (pull && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

// File: rtl/sktfi_engine.sv
// Back end: binary search over the key memory, shift-insert and result register.
`include "sorted_key_table_find_or_insert_defines.svh"
module sktfi_engine import sktfi_pkg::*; #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sktfi_req_t        req,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [SLOT_W-1:0] slot_index,
	output logic              was_present,
	output logic              table_full,
	output logic [USED_W-1:0] entries_used
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_PROBE    = 3'd1;
	localparam logic [2:0] ST_CMP      = 3'd2;
	localparam logic [2:0] ST_SHIFT_RD = 3'd3;
	localparam logic [2:0] ST_SHIFT_WR = 3'd4;
	localparam logic [2:0] ST_RESULT   = 3'd5;

	logic [KEY_W-1:0]  store_mem [TABLE_DEPTH];
	logic [KEY_W-1:0]  rd_data_q;
	logic [2:0]        state_q;
	logic [KEY_W-1:0]  key_q;
	logic [CW-1:0]     lo_q;
	logic [CW-1:0]     hi_q;
	logic [AW-1:0]     mid_q;
	logic [CW-1:0]     j_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     slot_q;
	logic              present_q;
	logic              full_q;
	logic              out_valid_q;
	logic [SLOT_W-1:0] slot_index_q;
	logic              was_present_q;
	logic              table_full_q;
	logic [USED_W-1:0] entries_used_q;

	logic [CW-1:0]        span;
	logic [CW-1:0]        mid_wide;
	logic [AW-1:0]        mid_c;
	logic [CW-1:0]        j_dec;
	logic                 mem_re;
	logic                 mem_we;
	logic [AW-1:0]        mem_raddr;
	logic [AW-1:0]        mem_waddr;
	logic [KEY_W-1:0]     mem_wdata;
	logic [CW+SLOT_W-1:0] slot_ext;
	logic [CW+USED_W-1:0] used_ext;

	assign span     = hi_q - lo_q;
	assign mid_wide = lo_q + (span >> 1);
	assign mid_c    = mid_wide[AW-1:0];
	assign j_dec    = j_q - CW'(1);
	assign slot_ext = {{SLOT_W{1'b0}}, slot_q};
	assign used_ext = {{USED_W{1'b0}}, count_q};

	assign pop = (state_q == ST_IDLE) && req.valid;

	// Probe reads at the midpoint; the shift reads the entry just below the hole.
	assign mem_re    = ((state_q == ST_PROBE) && (hi_q > lo_q))
	                || ((state_q == ST_SHIFT_RD) && (j_q > lo_q));
	assign mem_raddr = (state_q == ST_PROBE) ? mid_c : j_dec[AW-1:0];
	assign mem_we    = (state_q == ST_SHIFT_WR)
	                || ((state_q == ST_SHIFT_RD) && (j_q <= lo_q));
	assign mem_waddr = (state_q == ST_SHIFT_WR) ? j_q[AW-1:0] : lo_q[AW-1:0];
	assign mem_wdata = (state_q == ST_SHIFT_WR) ? rd_data_q : key_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= store_mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			key_q          <= '0;
			lo_q           <= '0;
			hi_q           <= '0;
			mid_q          <= '0;
			j_q            <= '0;
			count_q        <= '0;
			slot_q         <= '0;
			present_q      <= 1'b0;
			full_q         <= 1'b0;
			out_valid_q    <= 1'b0;
			slot_index_q   <= '0;
			was_present_q  <= 1'b0;
			table_full_q   <= 1'b0;
			entries_used_q <= '0;
		end else begin
			// Drop the result once it transfers, unless a new one loads this cycle.
			if (out_valid_q && out_ready && (state_q != ST_RESULT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						key_q   <= req.key;
						lo_q    <= '0;
						hi_q    <= count_q;
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (hi_q > lo_q) begin
						mid_q   <= mid_c;
						state_q <= ST_CMP;
					end else if (count_q == DEPTH_C) begin
						slot_q    <= '0;
						present_q <= 1'b0;
						full_q    <= 1'b1;
						state_q   <= ST_RESULT;
					end else begin
						j_q     <= count_q;
						state_q <= ST_SHIFT_RD;
					end
				end
				ST_CMP: begin
					if (key_q == rd_data_q) begin
						slot_q    <= CW'(mid_q);
						present_q <= 1'b1;
						full_q    <= 1'b0;
						state_q   <= ST_RESULT;
					end else if (key_q < rd_data_q) begin
						hi_q    <= CW'(mid_q);
						state_q <= ST_PROBE;
					end else begin
						lo_q    <= CW'(mid_q) + CW'(1);
						state_q <= ST_PROBE;
					end
				end
				ST_SHIFT_RD: begin
					if (j_q > lo_q) begin
						state_q <= ST_SHIFT_WR;
					end else begin
						count_q   <= count_q + CW'(1);
						slot_q    <= lo_q;
						present_q <= 1'b0;
						full_q    <= 1'b0;
						state_q   <= ST_RESULT;
					end
				end
				ST_SHIFT_WR: begin
					j_q     <= j_dec;
					state_q <= ST_SHIFT_RD;
				end
				ST_RESULT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q    <= 1'b1;
						slot_index_q   <= slot_ext[SLOT_W-1:0];
						was_present_q  <= present_q;
						table_full_q   <= full_q;
						entries_used_q <= used_ext[USED_W-1:0];
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign slot_index   = slot_index_q;
	assign was_present  = was_present_q;
	assign table_full   = table_full_q;
	assign entries_used = entries_used_q;

	`SKTFI_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= DEPTH_C, "entry count above depth")
	`SKTFI_ASSERT_NOW(a_full_only_when_full, clk, arst_n, (state_q == ST_RESULT) && full_q, count_q == DEPTH_C, "full result with room left")
	`SKTFI_ASSERT_NOW(a_hit_not_full, clk, arst_n, state_q == ST_RESULT, !(present_q && full_q), "hit and full at once")
	`SKTFI_ASSERT_NOW(a_shift_above_hole, clk, arst_n, state_q == ST_SHIFT_WR, j_q > lo_q, "shift below insertion slot")
	`SKTFI_ASSERT_NEXT(a_pop_starts_search, clk, arst_n, pop, state_q == ST_PROBE, "pop without search start")

endmodule

// File: rtl/sorted_key_table_find_or_insert.sv
// Sorted key table: each transfer on the input brings one 31-bit key; the block
// binary-searches a table of up to TABLE_DEPTH keys kept in ascending unsigned
// order, reports the slot if the key is stored, and otherwise opens a hole by
// moving the higher entries up one slot and writes the key there. A key that is
// absent from a full table changes nothing and comes back with table_full set.
// Exactly one result transfer follows each input transfer, in order. Keys land
// in a two-entry queue, so input transfers continue while the engine works and
// while a result waits on the output, until the queue is full. The engine works
// one key at a time, on the key memory with a registered read: each probe is a
// read in PROBE and a compare in CMP, and each moved entry is a read in SHIFT_RD
// and a write in SHIFT_WR. A search makes at most ceil(log2(entries+1)) probes.
// The table contents are not cleared at reset; only the entry count is.
module sorted_key_table_find_or_insert import sktfi_pkg::*; #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [KEY_W-1:0]  lookup_key,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [SLOT_W-1:0] slot_index,
	output logic              was_present,
	output logic              table_full,
	output logic [USED_W-1:0] entries_used
);

	// Queued request toward the engine and its dequeue strobe.
	sktfi_req_t req;
	logic       pop;

	sktfi_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.lookup_key (lookup_key),
		.req        (req),
		.pop        (pop)
	);

	// Search, shift-insert and hold the result until the output transfer.
	sktfi_engine #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.slot_index   (slot_index),
		.was_present  (was_present),
		.table_full   (table_full),
		.entries_used (entries_used)
	);

endmodule

// File: verif/sorted_key_table_find_or_insert_tb.sv
// Self-checking testbench for the sorted key table find-or-insert block.
module sorted_key_table_find_or_insert_tb import sktfi_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_DEPTH  = 64;
	// Cycles with no transfer on either side before the run is declared hung.
	// This leaves a wide margin over the worst insert, which moves up to 63
	// entries, and over the long output hold.
	localparam int STALL_LIMIT  = 3000;
	localparam int OUT_HOLD_LEN = 300;
	localparam int SETTLE_LEN   = 200;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              present;
		logic              full;
		logic [USED_W-1:0] used;
	} slot_report_t;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              in_valid     = 1'b0;
	logic              in_ready;
	logic [KEY_W-1:0]  lookup_key   = '0;
	logic              out_valid;
	logic              out_ready    = 1'b0;
	logic [SLOT_W-1:0] slot_index;
	logic              was_present;
	logic              table_full;
	logic [USED_W-1:0] entries_used;

	// Shadow copy of the table, updated at each input transfer.
	logic [KEY_W-1:0]  shadow_keys [TABLE_DEPTH];
	int unsigned       shadow_count = 0;
	slot_report_t      pending_slot_reports [$];

	int  error_count    = 0;
	int  keys_sent      = 0;
	int  reports_seen   = 0;
	int  hit_count      = 0;
	int  insert_count   = 0;
	int  full_count     = 0;
	int  quiet_cycles   = 0;
	bit  sender_idling  = 1'b0;
	bit  receiver_idling = 1'b0;
	int  hold_request   = 0;
	int  rx_wait_left   = 0;

	sorted_key_table_find_or_insert #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.lookup_key   (lookup_key),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.slot_index   (slot_index),
		.was_present  (was_present),
		.table_full   (table_full),
		.entries_used (entries_used)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Binary search the shadow table; on a miss with room, open a hole by
	// moving the upper entries up one slot and drop the key in.
	function automatic slot_report_t predict_find_or_insert(logic [KEY_W-1:0] key);
		int unsigned  lo;
		int unsigned  hi;
		int unsigned  mid;
		int unsigned  slot;
		int unsigned  i;
		bit           hit;
		slot_report_t rep;
		lo  = 0;
		hi  = shadow_count;
		mid = 0;
		hit = 1'b0;
		while (hi > lo && !hit) begin
			mid = lo + (hi - lo) / 2;
			if (key == shadow_keys[mid]) begin
				hit = 1'b1;
			end else if (key < shadow_keys[mid]) begin
				hi = mid;
			end else begin
				lo = mid + 1;
			end
		end
		rep = '0;
		if (hit) begin
			slot = mid;
			rep.present = 1'b1;
			hit_count++;
		end else if (shadow_count >= TABLE_DEPTH) begin
			slot = 0;
			rep.full = 1'b1;
			full_count++;
		end else begin
			for (i = shadow_count; i > lo; i--) begin
				shadow_keys[i] = shadow_keys[i-1];
			end
			shadow_keys[lo] = key;
			shadow_count++;
			slot = lo;
			insert_count++;
		end
		rep.slot = slot[SLOT_W-1:0];
		rep.used = shadow_count[USED_W-1:0];
		return rep;
	endfunction

	function automatic bit key_stored(logic [KEY_W-1:0] key);
		int unsigned i;
		for (i = 0; i < shadow_count; i++) begin
			if (shadow_keys[i] == key) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Walk upward from a seed until a key that is not stored turns up.
	function automatic logic [KEY_W-1:0] absent_near(logic [KEY_W-1:0] seed);
		logic [KEY_W-1:0] k;
		k = seed;
		while (key_stored(k)) begin
			k = k + 1'b1;
		end
		return k;
	endfunction

	function automatic logic [KEY_W-1:0] random_stored_key();
		return shadow_keys[$urandom_range(0, shadow_count - 1)];
	endfunction

	// Fresh keys: full range, around stored keys, and crowded at both ends.
	function automatic logic [KEY_W-1:0] random_fresh_key();
		logic [31:0] r;
		r = $urandom;
		unique case ($urandom_range(0, 4))
			0: return r[KEY_W-1:0];
			1: return r[KEY_W-1:0];
			2: begin
				if (shadow_count == 0) begin
					return r[KEY_W-1:0];
				end
				return KEY_W'(random_stored_key() + (r[0] ? 1 : -1));
			end
			3: return KEY_W'($urandom_range(0, 255));
			default: return {KEY_W{1'b1}} - KEY_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic report_mismatch(string field, int got, int want);
		$display("%0t mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
		error_count++;
	endtask

	// Offer one key and hold it until the transfer; valid stays high afterwards,
	// unless sender_idling adds a random gap, so the next key can follow back to back.
	task automatic send_key(logic [KEY_W-1:0] key);
		in_valid   <= 1'b1;
		lookup_key <= key;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		pending_slot_reports.push_back(predict_find_or_insert(key));
		keys_sent++;
		if (sender_idling && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	task automatic sender_idle();
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_slot_reports.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Empty table, front and back inserts, hits at both ends, alternating bits.
	task automatic test_empty_and_extremes();
		sender_idling   = 1'b1;
		receiver_idling = 1'b1;
		send_key(31'h4000_0000);
		send_key(31'h0000_0000);
		send_key(31'h7FFF_FFFF);
		send_key(31'h0000_0000);
		send_key(31'h7FFF_FFFF);
		send_key(31'h4000_0000);
		send_key(31'h3FFF_FFFF);
		send_key(31'h4000_0001);
		send_key(31'h2AAA_AAAA);
		send_key(31'h5555_5555);
		send_key(31'h0000_0001);
		send_key(31'h7FFF_FFFE);
		sender_idle();
		wait_drained();
	endtask

	// Grow the table toward a target count with a mix of fresh keys and hits.
	task automatic test_table_growth(int unsigned target);
		while (shadow_count < target) begin
			if ($urandom_range(0, 9) < 6) begin
				send_key(random_fresh_key());
			end else begin
				send_key(random_stored_key());
			end
		end
		sender_idle();
		wait_drained();
	endtask

	// Hold the output off for a long stretch while keys keep coming, so the
	// input queue fills and in_ready drops.
	task automatic test_output_hold();
		int i;
		sender_idling = 1'b0;
		hold_request  = OUT_HOLD_LEN;
		for (i = 0; i < 8; i++) begin
			if (i[0]) begin
				send_key(random_stored_key());
			end else begin
				send_key(random_fresh_key());
			end
		end
		sender_idle();
		wait_drained();
		sender_idling = 1'b1;
	endtask

	// Full table: hits at the lowest, middle and highest slot, misses that must
	// leave the table untouched.
	task automatic test_full_table();
		send_key(shadow_keys[0]);
		send_key(shadow_keys[TABLE_DEPTH-1]);
		send_key(absent_near(shadow_keys[0]));
		send_key(absent_near(shadow_keys[TABLE_DEPTH/2]));
		send_key(absent_near(KEY_W'($urandom)));
		send_key(shadow_keys[TABLE_DEPTH/2]);
		send_key(absent_near(KEY_W'($urandom)));
		sender_idle();
		wait_drained();
	endtask

	// Let everything drain before sending again.
	task automatic test_sender_pause();
		int i;
		for (i = 0; i < 5; i++) begin
			send_key(random_stored_key());
		end
		sender_idle();
		wait_drained();
		repeat ($urandom_range(10, 40)) @(posedge clk);
		for (i = 0; i < 5; i++) begin
			send_key(absent_near(random_fresh_key()));
		end
		sender_idle();
		wait_drained();
	endtask

	task automatic test_random_lookups(int count);
		int i;
		for (i = 0; i < count; i++) begin
			if ($urandom_range(0, 1) == 0) begin
				send_key(random_stored_key());
			end else begin
				send_key(random_fresh_key());
			end
		end
		sender_idle();
		wait_drained();
	endtask

	// Closing stretch: both sides run flat out.
	task automatic test_back_to_back(int count);
		sender_idling   = 1'b0;
		receiver_idling = 1'b0;
		test_random_lookups(count);
	endtask

	// Receiver: random stall bursts, plus the long hold when a test asks.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (hold_request > 0) begin
				rx_wait_left = hold_request;
				hold_request = 0;
			end else if (rx_wait_left == 0 && receiver_idling && $urandom_range(0, 4) == 0) begin
				rx_wait_left = $urandom_range(1, 9);
			end
			if (rx_wait_left > 0) begin
				out_ready <= 1'b0;
				rx_wait_left--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Compare each result transfer with the oldest prediction.
	always @(posedge clk) begin
		slot_report_t want;
		if (arst_n && out_valid && out_ready) begin
			reports_seen++;
			if (pending_slot_reports.size() == 0) begin
				$display("%0t unexpected result transfer, slot %0d", $realtime, slot_index);
				error_count++;
			end else begin
				want = pending_slot_reports.pop_front();
				if (slot_index !== want.slot) begin
					report_mismatch("slot_index", int'(slot_index), int'(want.slot));
				end
				if (was_present !== want.present) begin
					report_mismatch("was_present", int'(was_present), int'(want.present));
				end
				if (table_full !== want.full) begin
					report_mismatch("table_full", int'(table_full), int'(want.full));
				end
				if (entries_used !== want.used) begin
					report_mismatch("entries_used", int'(entries_used), int'(want.used));
				end
			end
		end
	end

	// Watchdog: count cycles in which neither side transfers.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t timeout: no transfer for %0d cycles, %0d results outstanding",
					$realtime, quiet_cycles, pending_slot_reports.size());
				$display("sorted_key_table_find_or_insert_tb: done, errors");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_and_extremes();
		test_table_growth(TABLE_DEPTH - 20);
		test_output_hold();
		test_table_growth(TABLE_DEPTH);
		test_full_table();
		test_sender_pause();
		test_random_lookups(320);
		test_back_to_back(60);

		wait_drained();
		repeat (SETTLE_LEN) @(posedge clk);

		$display("covered %0d keys: %0d hits, %0d inserts, %0d misses on a full table",
			keys_sent, hit_count, insert_count, full_count);
		$display("checked %0d results, %0d mismatches", reports_seen, error_count);
		if (error_count == 0 && pending_slot_reports.size() == 0) begin
			$display("sorted_key_table_find_or_insert_tb: done, clean");
		end else begin
			$display("sorted_key_table_find_or_insert_tb: done, errors");
		end
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/sktfi_pkg.sv
rtl/sktfi_front.sv
rtl/sktfi_engine.sv
rtl/sorted_key_table_find_or_insert.sv
verif/sorted_key_table_find_or_insert_tb.sv
